FILE: rtl/core/structure_factor_accumulator_top_macros.svh
// Assertion macros for the structure factor accumulator.
// Used by sfa_back; no other dependencies.
`ifndef STRUCTURE_FACTOR_ACCUMULATOR_TOP_MACROS_SVH
`define STRUCTURE_FACTOR_ACCUMULATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SFA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SFA_ASSERT(lbl, prop, msg)
`define SFA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/core/sfa_pkg.sv
// Package for the structure factor accumulator: constants, types, sine-table entry function.
// No dependencies.
package sfa_pkg;
  localparam int unsigned MaxAtoms   = 4096;
  localparam int unsigned MaxFrames  = 65536;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned QueueDepth = 4;

  localparam logic [1:0] RegWaveX = 2'd0;
  localparam logic [1:0] RegWaveY = 2'd1;
  localparam logic [1:0] RegWaveZ = 2'd2;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // one accepted beat after phase lookup
  typedef struct packed {
    logic signed [16:0] cos_v;
    logic signed [16:0] sin_v;
    logic               summed;
    logic               end_atom;
    logic               end_frame;
  } sfa_item_t;

  typedef struct packed {
    logic        valid;
    logic [27:0] value;
    logic        sat;
  } sfa_res_t;

  function automatic logic [15:0] sine_entry(int unsigned k, int unsigned depth);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] r;
    x = (HalfPiQ30 * 64'(k)) / 64'(depth);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (64'(sum) + 64'd16384) >> 15;
    return (r > 64'd32767) ? 16'd32767 : r[15:0];
  endfunction
endpackage

FILE: rtl/core/sfa_front.sv
// Front end: computes the phase, looks up cos/sin, classifies the beat.
// Depends on sfa_pkg.
module sfa_front #(
  parameter int unsigned MAX_ATOMS   = sfa_pkg::MaxAtoms,
  parameter int unsigned TABLE_DEPTH = sfa_pkg::TableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [5:0]          wave_x_i,
  input  logic [5:0]          wave_y_i,
  input  logic [5:0]          wave_z_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic                last_atom_i,
  input  logic                last_frame_i,
  output logic                item_valid_o,
  input  logic                item_stall_i,
  output sfa_pkg::sfa_item_t  item_o
);
  localparam int unsigned TW = $clog2(TABLE_DEPTH);
  localparam int unsigned AW = $clog2(MAX_ATOMS + 1);

  logic [15:0] rom [TABLE_DEPTH];
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) rom[k] = sfa_pkg::sine_entry(k, TABLE_DEPTH);
  end

  // stage 1: phase; stage 2: lookup
  logic        s1_v_q, s1_sum_q, s1_ea_q, s1_ef_q;
  logic [23:0] s1_ph_q;
  logic [AW-1:0] cnt_q, cnt_d;
  logic        adv;
  logic [23:0] ph_d;

  assign adv = !item_valid_o || !item_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    ph_d = 24'(wave_x_i * pos_x_i[23:0]) + 24'(wave_y_i * pos_y_i[23:0])
         + 24'(wave_z_i * pos_z_i[23:0]);
    cnt_d = cnt_q;
    if (in_valid_i && adv) begin
      if (last_atom_i) cnt_d = '0;
      else if (cnt_q < AW'(MAX_ATOMS)) cnt_d = cnt_q + 1'b1;
    end
  end

  logic [TW+1:0] idx;
  logic [TW-1:0] off;
  logic [TW:0]   noff;
  logic signed [16:0] a, b;
  assign idx  = s1_ph_q[23 -: TW+2];
  assign off  = idx[TW-1:0];
  assign noff = (TW+1)'(TABLE_DEPTH) - {1'b0, off};
  assign a = 17'(rom[off]);
  assign b = noff[TW] ? 17'sd32767 : 17'(rom[noff[TW-1:0]]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      item_valid_o <= 1'b0;
      cnt_q <= '0;
    end else if (adv) begin
      cnt_q <= cnt_d;
      s1_v_q <= in_valid_i;
      item_valid_o <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ph_q  <= ph_d;
      s1_sum_q <= cnt_q < AW'(MAX_ATOMS);
      s1_ea_q  <= last_atom_i;
      s1_ef_q  <= last_frame_i;
      item_o.summed    <= s1_sum_q;
      item_o.end_atom  <= s1_ea_q;
      item_o.end_frame <= s1_ef_q;
      case (idx[TW+1:TW])
        2'd0: begin item_o.cos_v <= b;  item_o.sin_v <= a;  end
        2'd1: begin item_o.cos_v <= -a; item_o.sin_v <= b;  end
        2'd2: begin item_o.cos_v <= -b; item_o.sin_v <= -a; end
        default: begin item_o.cos_v <= a; item_o.sin_v <= -b; end
      endcase
    end
  end
endmodule

FILE: rtl/core/sfa_queue.sv
// Short FIFO between front and back ends.
// Depends on sfa_pkg.
module sfa_queue #(
  parameter int unsigned DEPTH = sfa_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_stall_o,
  input  sfa_pkg::sfa_item_t wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_stall_i,
  output sfa_pkg::sfa_item_t rd_data_o
);
  localparam int unsigned PW = $clog2(DEPTH);
  sfa_pkg::sfa_item_t mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic wr, rd;

  assign wr_stall_o = cnt_q == (PW+1)'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

FILE: rtl/core/sfa_back.sv
// Back end: frame sums, power accumulation, serial normalization, result register.
// Depends on sfa_pkg and the assertion macro header.
`include "structure_factor_accumulator_top_macros.svh"
module sfa_back #(
  parameter int unsigned MAX_ATOMS  = sfa_pkg::MaxAtoms,
  parameter int unsigned MAX_FRAMES = sfa_pkg::MaxFrames
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_stall_o,
  input  sfa_pkg::sfa_item_t item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [27:0]        structure_factor_o,
  output logic               saturated_o,
  output logic               done_res_o
);
  localparam int unsigned AW = $clog2(MAX_ATOMS + 1);
  localparam int unsigned FW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [3:0] {
    StAcc = 4'b0001, StPow = 4'b0010, StDiv = 4'b0100, StOut = 4'b1000
  } st_e;

  st_e st_q;
  logic signed [29:0] re_q, im_q;
  logic signed [29:0] re_n, im_n;
  logic signed [59:0] re_sq, im_sq;
  logic [63:0] pow_q;
  logic [AW-1:0] atoms_q;
  logic [FW-1:0] frames_q;
  logic ovf_q, last_q;
  logic [59:0] sq_re_q, sq_im_q;
  logic [80:0] rem_q;
  logic [28:0] quo_q;
  logic [6:0]  bit_q;
  logic [AW+FW-1:0] div_q;
  logic take;
  logic nb;
  logic fire;

  assign item_stall_o = st_q != StAcc;
  assign take = item_valid_i && st_q == StAcc;
  assign fire = st_q == StOut && (!out_valid_o || !out_stall_i);

  assign re_n = re_q + (item_i.summed ? 30'(item_i.cos_v) : 30'sd0);
  assign im_n = im_q + (item_i.summed ? 30'(item_i.sin_v) : 30'sd0);
  assign re_sq = re_n * re_n;
  assign im_sq = im_n * im_n;

  logic [64:0] psum;
  assign psum = 65'(pow_q) + 65'(sq_re_q) + 65'(sq_im_q);
  assign nb = bit_q[6] ? 1'b0 : pow_q[6'd63 - bit_q[5:0]];
  logic [81:0] trial;
  assign trial = {rem_q, nb} - 82'(div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StAcc;
      re_q <= '0; im_q <= '0; pow_q <= '0;
      atoms_q <= '0; frames_q <= '0; ovf_q <= 1'b0;
      out_valid_o <= 1'b0;
      last_q <= 1'b0;
      sq_re_q <= '0; sq_im_q <= '0;
      rem_q <= '0; quo_q <= '0; bit_q <= '0; div_q <= '0;
      saturated_o <= 1'b0;
      structure_factor_o <= '0;
      done_res_o <= 1'b0;
    end else begin
      if (fire) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (st_q)
        StAcc: if (take) begin
          if (item_i.summed) atoms_q <= atoms_q + 1'b1;
          if (item_i.end_atom) begin
            sq_re_q <= re_sq;
            sq_im_q <= im_sq;
            re_q <= '0; im_q <= '0;
            last_q <= item_i.end_frame;
            st_q <= StPow;
          end else if (item_i.summed) begin
            re_q <= re_n;
            im_q <= im_n;
          end
        end
        StPow: begin
          if (frames_q < FW'(MAX_FRAMES)) begin
            frames_q <= frames_q + 1'b1;
            if (psum[64]) begin pow_q <= '1; ovf_q <= 1'b1; end
            else pow_q <= psum[63:0];
          end
          if (!last_q) begin
            atoms_q <= '0;
            st_q <= StAcc;
          end else begin
            div_q <= (AW+FW)'(atoms_q)
                     * (AW+FW)'(frames_q + FW'(frames_q < FW'(MAX_FRAMES)));
            rem_q <= '0;
            quo_q <= '0;
            bit_q <= '0;
            st_q <= StDiv;
          end
        end
        StDiv: begin
          // restoring division of pow<<16, 80 quotient bits, saturating at 28
          if (trial[81]) rem_q <= {rem_q[79:0], nb};
          else rem_q <= trial[80:0];
          quo_q <= (quo_q[28] || quo_q[27]) ? 29'h1000_0000 : {quo_q[27:0], !trial[81]};
          bit_q <= bit_q + 1'b1;
          if (bit_q == 7'd79) st_q <= StOut;
        end
        StOut: if (fire) begin
          saturated_o <= ovf_q;
          structure_factor_o <= (div_q == '0) ? 28'd0 : (quo_q[28] ? '1 : quo_q[27:0]);
          done_res_o <= 1'b1;
          re_q <= '0; im_q <= '0; pow_q <= '0;
          atoms_q <= '0; frames_q <= '0; ovf_q <= 1'b0;
          st_q <= StAcc;
        end
        default: st_q <= StAcc;
      endcase
    end
  end

  `SFA_ASSERT(a_stall_busy, (st_q != StAcc) |-> item_stall_o, "back end took a beat while busy")
  `SFA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(structure_factor_o), "result dropped under stall")
  `SFA_ASSERT_NEXT(a_clear, st_q == StOut && (!out_valid_o || !out_stall_i), pow_q == '0 && frames_q == '0, "run state not cleared")
endmodule

FILE: rtl/core/structure_factor_accumulator_top.sv
// Top level of the structure factor accumulator: APB registers, front, queue, back.
// Depends on sfa_pkg, sfa_front, sfa_queue, sfa_back.
//
//  port group   dir   handshake          payload
//  in           in    in_valid/stall     pos_x/y/z, last_atom, last_frame
//  out          out   out_valid/stall    structure_factor, saturated, done_res
//  apb          in    psel/penable       wave_index_x/y/z
//
// One position per cycle while a frame streams; the front end is a two-stage
// phase/lookup pipe. Each frame end passes through a power-add state.
// The trajectory end runs a bit-serial divider before the result.
// Reset clears all run state; a stalled result holds the back end.
module structure_factor_accumulator_top #(
  parameter int unsigned MAX_ATOMS   = sfa_pkg::MaxAtoms,
  parameter int unsigned MAX_FRAMES  = sfa_pkg::MaxFrames,
  parameter int unsigned TABLE_DEPTH = sfa_pkg::TableDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic               last_atom_i,
  input  logic               last_frame_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [27:0]        structure_factor_o,
  output logic               saturated_o,
  output logic               done_res_o
);
  logic [5:0] wx_q, wy_q, wz_q;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_q <= '0; wy_q <= '0; wz_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        sfa_pkg::RegWaveX: wx_q <= pwdata[5:0];
        sfa_pkg::RegWaveY: wy_q <= pwdata[5:0];
        sfa_pkg::RegWaveZ: wz_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sfa_pkg::RegWaveX: prdata = {26'd0, wx_q};
      sfa_pkg::RegWaveY: prdata = {26'd0, wy_q};
      sfa_pkg::RegWaveZ: prdata = {26'd0, wz_q};
      default: prdata = '0;
    endcase
  end

  logic f_v, f_s, q_v, q_s;
  sfa_pkg::sfa_item_t f_d, q_d;

  sfa_front #(.MAX_ATOMS(MAX_ATOMS), .TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk_i, .rst_ni, .wave_x_i(wx_q), .wave_y_i(wy_q), .wave_z_i(wz_q),
    .in_valid_i, .in_stall_o, .pos_x_i, .pos_y_i, .pos_z_i, .last_atom_i, .last_frame_i,
    .item_valid_o(f_v), .item_stall_i(f_s), .item_o(f_d)
  );

  sfa_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_v), .wr_stall_o(f_s), .wr_data_i(f_d),
    .rd_valid_o(q_v), .rd_stall_i(q_s), .rd_data_o(q_d)
  );

  sfa_back #(.MAX_ATOMS(MAX_ATOMS), .MAX_FRAMES(MAX_FRAMES)) u_back (
    .clk_i, .rst_ni, .item_valid_i(q_v), .item_stall_o(q_s), .item_i(q_d),
    .out_valid_o, .out_stall_i, .structure_factor_o, .saturated_o, .done_res_o
  );
endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for structure_factor_accumulator_top: streams atom positions,
// predicts S(q) per trajectory and compares every result beat. Depends on sfa_pkg.
`timescale 1ns / 100ps

module tb_top;
  localparam int unsigned Depth = 1024;
  localparam int unsigned WdLimit = 5000;
  localparam logic [27:0] SfMax = 28'hFFFFFFF;

  typedef struct {
    logic [27:0] sf;
    logic        sat;
  } sf_result_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic        la, lf;
    logic        typed;
    logic [27:0] sf;
    logic        sat;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic last_atom_i = 1'b0, last_frame_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [27:0] structure_factor_o;
  logic saturated_o, done_res_o;

  always #1 clk_i = ~clk_i;

  structure_factor_accumulator_top u_dut (.*);

  // predictor state
  logic [15:0] sine_q15 [Depth];
  logic [5:0] wave_x, wave_y, wave_z;
  int signed re_acc, im_acc;
  longint unsigned power_acc;
  int unsigned atoms, frames;
  bit ovf;
  sf_result_t sf_expected [$];

  int unsigned errors, beats_in, results_seen, wd_count;
  int unsigned send_idle_pct, recv_stall_pct;

  function automatic logic [15:0] quarter_sine(int unsigned k);
    longint unsigned x, x2, term, r;
    longint signed acc;
    x = 64'd1686629713 * 64'(k) / 64'(Depth);
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    r = (64'(acc) + 64'd16384) >> 15;
    return (r > 64'd32767) ? 16'd32767 : r[15:0];
  endfunction

  function automatic int signed sine_at(int unsigned j);
    return (j >= Depth) ? 32767 : int'(sine_q15[j]);
  endfunction

  function automatic void clear_traj();
    re_acc = 0;
    im_acc = 0;
    power_acc = 0;
    atoms = 0;
    frames = 0;
    ovf = 0;
  endfunction

  // returns 1 when the beat closes a trajectory
  function automatic bit sf_accumulate(logic [31:0] px, py, pz, logic la, lf,
                                       output sf_result_t res);
    logic [31:0] ph;
    int unsigned idx, quad, off;
    int signed a, b, c, s;
    longint unsigned p, dv, q, r, v;
    if (atoms < sfa_pkg::MaxAtoms) begin
      ph = 32'(wave_x) * px + 32'(wave_y) * py + 32'(wave_z) * pz;
      idx = ph[23:12];
      quad = idx / Depth;
      off = idx % Depth;
      a = sine_at(off);
      b = sine_at(Depth - off);
      case (quad)
        0: begin c = b; s = a; end
        1: begin c = -a; s = b; end
        2: begin c = -b; s = -a; end
        default: begin c = a; s = -b; end
      endcase
      re_acc += c;
      im_acc += s;
      atoms++;
    end
    if (!la) return 0;
    if (frames < sfa_pkg::MaxFrames) begin
      p = 64'(longint'(re_acc) * longint'(re_acc)) + 64'(longint'(im_acc) * longint'(im_acc));
      if (power_acc > ~64'd0 - p) begin
        power_acc = ~64'd0;
        ovf = 1;
      end else power_acc += p;
      frames++;
    end
    re_acc = 0;
    im_acc = 0;
    if (!lf) begin
      atoms = 0;
      return 0;
    end
    dv = 64'(atoms) * 64'(frames);
    if (dv == 0) v = 0;
    else begin
      q = power_acc / dv;
      r = power_acc % dv;
      if (q > 64'(SfMax >> 16)) v = SfMax;
      else begin
        v = (q << 16) + (r << 16) / dv;
        if (v > 64'(SfMax)) v = SfMax;
      end
    end
    res.sf = v[27:0];
    res.sat = ovf;
    clear_traj();
    return 1;
  endfunction

  task automatic send_beat(logic [31:0] px, py, pz, logic la, lf,
                           bit typed = 0, logic [27:0] tsf = '0, logic tsat = 0);
    sf_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    last_atom_i <= la;
    last_frame_i <= lf;
    do @(posedge clk_i); while (in_stall_o);
    beats_in++;
    if (sf_accumulate(px, py, pz, la, lf, res)) begin
      if (typed) begin
        res.sf = tsf;
        res.sat = tsat;
      end
      sf_expected.push_back(res);
    end
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    while (sf_expected.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] reg_idx, logic [5:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    pwdata <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (reg_idx)
      sfa_pkg::RegWaveX: wave_x = val;
      sfa_pkg::RegWaveY: wave_y = val;
      default: wave_z = val;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_wave(logic [5:0] x, y, z);
    reg_write(sfa_pkg::RegWaveX, x);
    reg_write(sfa_pkg::RegWaveY, y);
    reg_write(sfa_pkg::RegWaveZ, z);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(511)) - 256) << 15;
      default: return $urandom;
    endcase
  endfunction

  // well-formed trajectories with random content, plus stray last_frame noise
  task automatic random_trajectories(int unsigned n_beats);
    int unsigned sent, nf, na;
    sent = 0;
    while (sent < n_beats) begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        na = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        for (int a = 0; a < na; a++) begin
          bit closing;
          closing = (a == na - 1);
          send_beat(rand_pos(), rand_pos(), rand_pos(), closing,
                    closing ? (f == nf - 1) : ($urandom_range(9) == 0));
          sent++;
        end
      end
    end
  endtask

  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (sf_expected.size() == 0) begin
        $display("%0t: unexpected result sf=%h sat=%b", $time, structure_factor_o, saturated_o);
        errors++;
      end else begin
        sf_result_t e;
        e = sf_expected.pop_front();
        if (structure_factor_o !== e.sf || saturated_o !== e.sat || done_res_o !== 1'b1) begin
          $display("%0t: mismatch expected sf=%h sat=%b done=1 actual sf=%h sat=%b done=%b",
                   $time, e.sf, e.sat, structure_factor_o, saturated_o, done_res_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
      wd_count <= 0;
    else wd_count <= wd_count + 1;
    if (wd_count >= WdLimit) begin
      $display("%0t: no progress for %0d cycles", $time, WdLimit);
      $display("status: fail");
      $finish;
    end
  end

  dir_row_t dir_rows [$];

  initial begin
    errors = 0;
    beats_in = 0;
    results_seen = 0;
    wd_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wave_x = '0;
    wave_y = '0;
    wave_z = '0;
    clear_traj();
    for (int k = 0; k < Depth; k++) sine_q15[k] = quarter_sine(k);

    // all-zero wave vector after reset: every atom gives cos=1, so one-atom runs saturate
    dir_rows = '{
      '{32'h0, 32'h0, 32'h0, 1, 1, 1, SfMax, 0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, SfMax, 0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 0, 1, 0, '0, 0},
      '{32'h0, 32'h0, 32'h0, 1, 1, 1, SfMax, 0}
    };
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz, dir_rows[i].la,
                dir_rows[i].lf, dir_rows[i].typed, dir_rows[i].sf, dir_rows[i].sat);
    idle_input();

    // half-turn cancellation, quadrant edges, extreme indices
    set_wave(6'd1, 6'd0, 6'd0);
    dir_rows = '{
      '{32'h0, 32'h0, 32'h0, 0, 0, 0, '0, 0},
      '{32'h0080_0000, 32'h0, 32'h0, 1, 1, 0, '0, 0},
      '{32'h0040_0000, 32'h0, 32'h0, 0, 0, 0, '0, 0},
      '{32'h00C0_0000, 32'h0, 32'h0, 0, 0, 0, '0, 0},
      '{32'h00FF_FFFF, 32'h0, 32'h0, 0, 1, 0, '0, 0},
      '{32'h0000_1000, 32'h0, 32'h0, 1, 0, 0, '0, 0},
      '{32'h0000_0FFF, 32'h0, 32'h0, 1, 1, 0, '0, 0}
    };
    foreach (dir_rows[i])
      send_beat(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz, dir_rows[i].la,
                dir_rows[i].lf);
    idle_input();
    set_wave(6'd63, 6'd63, 6'd63);
    for (int i = 0; i < 6; i++)
      send_beat(rand_pos(), rand_pos(), rand_pos(), (i % 2) == 1, i == 5);
    idle_input();

    for (int mode = 0; mode < 4; mode++) begin
      send_idle_pct = (mode == 1) ? 72 : (mode == 3) ? 28 : 0;
      recv_stall_pct = (mode == 2) ? 72 : (mode == 3) ? 28 : 0;
      if (mode == 0) set_wave(6'd0, 6'd63, 6'd1);
      else set_wave(6'($urandom_range(63)), 6'($urandom_range(63)), 6'($urandom_range(63)));
      random_trajectories(460);
      idle_input();
    end
    recv_stall_pct = 0;

    $display("covered %0d position beats and %0d results, lone frame marks and extremes included",
             beats_in, results_seen);
    $display("wave indices swept from all zero to all 63 under four idling mixes");
    if (errors == 0 && sf_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, sf_expected.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
